FILE: src/fanlvl_pkg.sv
// fanlvl_pkg: shared types and constants for the averaged-temperature fan controller
// used by fan_level_from_averaged_temperature_unit; no dependencies

package fanlvl_pkg;

  // configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SAMPLE = 2'd2;

  localparam int THR_W  = 10;
  localparam int TICK_W = 16;

  localparam logic [THR_W-1:0]  HIGH_THRESHOLD_RST   = 10'd60;
  localparam logic [THR_W-1:0]  LOW_THRESHOLD_RST    = 10'd45;
  localparam logic [TICK_W-1:0] TICKS_PER_SAMPLE_RST = 16'd100;

  // fan level codes
  localparam int LEVEL_W = 2;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_5V  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_9V  = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_12V = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

FILE: src/fanlvl_div.sv
// fanlvl_div: bit-serial restoring divider, one quotient bit per cycle
// standalone; used by fan_level_from_averaged_temperature_unit

module fanlvl_div #(
  parameter int DW = 15,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic          busy;
  logic [CNT_W-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= VW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[VW-1:0];
      end
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: src/fan_level_from_averaged_temperature_unit.sv
// fan_level_from_averaged_temperature_unit: top level of the fan controller
// depends on fanlvl_pkg and fanlvl_div

// Fan controller driven by a windowed average of temperature samples.
// Input channel s_*: one request per control tick. s_tuser selects the kind:
// 0 is a tick carrying temperature and the two phase flags, 1 shuts the fan
// down until reset. Output channel m_*: one result per request, with the fan
// level, the three drive pins and the current average.
// Every ticks_per_sample ticks the temperature goes into a ring of
// WINDOW_SAMPLES entries and the mean of the nonzero samples is recomputed.
// A tick that takes no sample or a shutdown request goes straight to the emit
// step, which loads the output register; no new request is taken before that.
// A sampling tick sweeps the ring one entry per cycle through the registered
// read port, runs the bit-serial divider (skipped when no sample in the window
// is nonzero, which gives an average of zero), then emits. s_tready is high
// only between requests.
// The result sits in an output register, so a new request is taken while the
// previous result still waits for m_tready; when the receiver stalls, the
// next result waits in the emit step and the input stops accepting.
// Reset (rst, synchronous) restores the register defaults, clears counters,
// the average and the shutdown latch; ring entries are read only once written.
// Configuration writes (cfg_we) are to be made only while the block is idle; the block does not enforce this.

module fan_level_from_averaged_temperature_unit #(
  parameter int WINDOW_SAMPLES = 30,
  parameter int TEMP_BITS      = 10
) (
  input  logic clk,
  input  logic rst,

  // configuration write port
  input  logic                            cfg_we,
  input  logic [fanlvl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fanlvl_pkg::CFG_DATA_W-1:0] cfg_data,

  // request side
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // tdata: temperature, startup_done, warmup_done, zero fill
  input  logic [((TEMP_BITS + 2 + 7) / 8) * 8-1:0] s_tdata,
  // tuser: mode
  input  logic                                   s_tuser,

  // result side
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // tdata: fan_level[1:0], fan_enable, select_12v, select_9v,
  // average_temperature, zero fill
  output logic [((TEMP_BITS + 5 + 7) / 8) * 8-1:0] m_tdata
);

  localparam int IN_W   = ((TEMP_BITS + 2 + 7) / 8) * 8;
  localparam int OUT_W  = ((TEMP_BITS + 5 + 7) / 8) * 8;
  localparam int CNT_W  = $clog2(WINDOW_SAMPLES + 1);
  localparam int ADDR_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int SUM_W  = $clog2(WINDOW_SAMPLES * ((1 << TEMP_BITS) - 1) + 1);
  localparam int CMP_W  = (TEMP_BITS > fanlvl_pkg::THR_W) ? TEMP_BITS : fanlvl_pkg::THR_W;
  localparam int TICK_W = fanlvl_pkg::TICK_W;

  // configuration registers
  logic [fanlvl_pkg::THR_W-1:0] high_threshold;
  logic [fanlvl_pkg::THR_W-1:0] low_threshold;
  logic [TICK_W-1:0]            ticks_per_sample;

  // control state
  fanlvl_pkg::state_t state, state_next;
  logic [TICK_W-1:0]    tick_count;
  logic [CNT_W-1:0]     sample_index;
  logic                 window_full;
  logic [TEMP_BITS-1:0] average_value;
  logic                 shut_down;
  logic                 startup_done;
  logic                 warmup_done;

  // window sweep
  logic [TEMP_BITS-1:0] sample_store [WINDOW_SAMPLES];
  logic [CNT_W-1:0]     win_count;
  logic [CNT_W-1:0]     rd_ptr;
  logic                 rd_pend;
  logic [TEMP_BITS-1:0] rd_data;
  logic [SUM_W-1:0]     sum;
  logic [CNT_W-1:0]     valid_cnt;

  // handshake and sequencing strobes
  logic accept;
  logic take_sample;
  logic sweep_done;
  logic div_start;
  logic div_done;
  logic out_load;
  logic [SUM_W-1:0] quotient;

  // sample slot: wraps to zero once the ring is full
  logic             idx_wrap;
  logic [CNT_W-1:0] idx_eff;

  // input fields
  logic [TEMP_BITS-1:0] in_temperature;
  logic                 in_startup_done;
  logic                 in_warmup_done;

  logic [fanlvl_pkg::LEVEL_W-1:0] level_next;
  logic [CMP_W-1:0] avg_x;
  logic [CMP_W-1:0] high_x;
  logic [CMP_W-1:0] low_x;

  assign in_temperature  = s_tdata[TEMP_BITS-1:0];
  assign in_startup_done = s_tdata[TEMP_BITS];
  assign in_warmup_done  = s_tdata[TEMP_BITS+1];

  assign accept      = s_tvalid && s_tready;
  assign take_sample = !s_tuser && (tick_count == ticks_per_sample);
  assign idx_wrap    = sample_index >= CNT_W'(WINDOW_SAMPLES);
  assign idx_eff     = idx_wrap ? '0 : sample_index;
  assign sweep_done  = (rd_ptr == win_count) && !rd_pend;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold   <= fanlvl_pkg::HIGH_THRESHOLD_RST;
      low_threshold    <= fanlvl_pkg::LOW_THRESHOLD_RST;
      ticks_per_sample <= fanlvl_pkg::TICKS_PER_SAMPLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fanlvl_pkg::CFG_HIGH_THRESHOLD:   high_threshold   <= cfg_data[fanlvl_pkg::THR_W-1:0];
        fanlvl_pkg::CFG_LOW_THRESHOLD:    low_threshold    <= cfg_data[fanlvl_pkg::THR_W-1:0];
        fanlvl_pkg::CFG_TICKS_PER_SAMPLE: ticks_per_sample <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fanlvl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      fanlvl_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = take_sample ? fanlvl_pkg::ST_SUM : fanlvl_pkg::ST_EMIT;
        end
      end
      fanlvl_pkg::ST_SUM: begin
        if (sweep_done) begin
          if (valid_cnt == '0) begin
            state_next = fanlvl_pkg::ST_EMIT;
          end else begin
            div_start  = 1'b1;
            state_next = fanlvl_pkg::ST_DIV;
          end
        end
      end
      fanlvl_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = fanlvl_pkg::ST_EMIT;
        end
      end
      fanlvl_pkg::ST_EMIT: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = fanlvl_pkg::ST_IDLE;
        end
      end
      default: state_next = fanlvl_pkg::ST_IDLE;
    endcase
  end

  // tick bookkeeping, shutdown latch and average
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      sample_index  <= '0;
      window_full   <= 1'b0;
      average_value <= '0;
      shut_down     <= 1'b0;
    end else begin
      if (accept) begin
        if (s_tuser) begin
          shut_down <= 1'b1;
        end else begin
          tick_count <= (take_sample ? '0 : tick_count) + 1'b1;
          if (take_sample) begin
            sample_index <= idx_eff + 1'b1;
            window_full  <= window_full || idx_wrap;
          end
        end
      end
      if (state == fanlvl_pkg::ST_SUM && sweep_done && valid_cnt == '0) begin
        average_value <= '0;
      end else if (state == fanlvl_pkg::ST_DIV && div_done) begin
        average_value <= quotient[TEMP_BITS-1:0];
      end
    end
  end

  // phase flags travel with the request
  always_ff @(posedge clk) begin
    if (accept && !s_tuser) begin
      startup_done <= in_startup_done;
      warmup_done  <= in_warmup_done;
    end
  end

  // ring memory: one write on a sampling tick, one registered read per sweep step
  always_ff @(posedge clk) begin
    if (accept && take_sample) begin
      sample_store[idx_eff[ADDR_W-1:0]] <= in_temperature;
    end
    if (state == fanlvl_pkg::ST_SUM && rd_ptr != win_count) begin
      rd_data <= sample_store[rd_ptr[ADDR_W-1:0]];
    end
  end

  // window sweep: before the first wrap the newest sample is left out
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (accept && take_sample) begin
      rd_pend <= 1'b0;
    end else if (state == fanlvl_pkg::ST_SUM) begin
      rd_pend <= rd_ptr != win_count;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take_sample) begin
      win_count <= (window_full || idx_wrap) ? CNT_W'(WINDOW_SAMPLES) : idx_eff;
      rd_ptr    <= '0;
      sum       <= '0;
      valid_cnt <= '0;
    end else if (state == fanlvl_pkg::ST_SUM) begin
      if (rd_ptr != win_count) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      // zero readings are invalid and do not count
      if (rd_pend && rd_data != '0) begin
        sum       <= sum + SUM_W'(rd_data);
        valid_cnt <= valid_cnt + 1'b1;
      end
    end
  end

  fanlvl_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (valid_cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  // level decision on the current average
  assign avg_x  = CMP_W'(average_value);
  assign high_x = CMP_W'(high_threshold);
  assign low_x  = CMP_W'(low_threshold);

  always_comb begin
    priority if (shut_down) begin
      level_next = fanlvl_pkg::LEVEL_OFF;
    end else if (!startup_done) begin
      level_next = fanlvl_pkg::LEVEL_12V;
    end else if (!warmup_done) begin
      level_next = (avg_x <= high_x) ? fanlvl_pkg::LEVEL_9V : fanlvl_pkg::LEVEL_12V;
    end else if (avg_x <= low_x) begin
      level_next = fanlvl_pkg::LEVEL_5V;
    end else if (avg_x <= high_x) begin
      level_next = fanlvl_pkg::LEVEL_9V;
    end else begin
      level_next = fanlvl_pkg::LEVEL_12V;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_W'({average_value,
                         level_next == fanlvl_pkg::LEVEL_9V,
                         level_next == fanlvl_pkg::LEVEL_12V,
                         level_next != fanlvl_pkg::LEVEL_OFF,
                         level_next});
    end
  end

  // upper tdata fill bits on the request side carry nothing
  logic unused_in_fill;
  assign unused_in_fill = ^s_tdata[IN_W-1:TEMP_BITS+2];

endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for fan_level_from_averaged_temperature_unit
// depends on fanlvl_pkg and the unit under src; drives requests, checks every result
// against an in-bench prediction of the fan level, drive pins and windowed average

module testbench;

  localparam int WINDOW      = 30;      // ring depth of the unit
  localparam int TEMP_W      = 10;
  localparam int IDX_W       = fanlvl_pkg::CFG_IDX_W;
  localparam int DATA_W      = fanlvl_pkg::CFG_DATA_W;
  localparam int CYCLE_LIMIT = 800000;  // watchdog limit on the whole run
  localparam int PHASES      = 13;      // the last one carries the shutdown requests
  localparam int LONG_HOLD   = 500;     // receiver hold-off, in cycles
  localparam int SETTLE      = 4;       // idle cycles before a register write

  // one result, unpacked from m_tdata
  typedef struct packed {
    logic [1:0]        level;
    logic              enable;
    logic              sel_12v;
    logic              sel_9v;
    logic [TEMP_W-1:0] average;
  } drive_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  // one line of the directed plan: a tick request or a register write
  typedef struct {
    row_kind_t              kind;
    logic [TEMP_W-1:0]      temp;
    logic                   startup_done;
    logic                   warmup_done;
    bit                     typed;      // expected value written by hand
    logic [1:0]             level;
    logic [TEMP_W-1:0]      average;
    logic [IDX_W-1:0]       index;
    logic [DATA_W-1:0]      value;
  } plan_row_t;

  logic clk;
  logic rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // temperature[9:0], startup_done, warmup_done, zero fill
  logic        s_tuser;   // mode: 0 tick, 1 shutdown
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // fan_level[1:0], fan_enable, select_12v, select_9v,
                          // average_temperature[9:0], zero fill

  fan_level_from_averaged_temperature_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // fan state as the bench sees it
  logic [15:0]       tick_cnt;
  int                ring_pos;
  bit                ring_wrapped;
  logic [TEMP_W-1:0] ring [WINDOW];
  logic [TEMP_W-1:0] avg_q;
  bit                off_latched;
  logic [1:0]        level_q;
  // register copies
  logic [TEMP_W-1:0] thr_high;
  logic [TEMP_W-1:0] thr_low;
  logic [15:0]       tick_period;

  drive_t    pending_drive [$];   // results still owed by the unit, oldest first
  plan_row_t plan [$];

  int  errors;
  int  results_seen;
  int  cycles;
  int  samples_taken;
  int  ring_wraps;
  int  requests_sent;
  int  shutdowns_sent;
  int  settings_written;
  bit  steady;            // no idling on either side while set
  bit  long_hold_done;
  int  hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pins follow from the level alone
  function automatic drive_t fan_pins(logic [1:0] level, logic [TEMP_W-1:0] average);
    drive_t d;
    d.level   = level;
    d.enable  = (level != fanlvl_pkg::LEVEL_OFF);
    d.sel_12v = (level == fanlvl_pkg::LEVEL_12V);
    d.sel_9v  = (level == fanlvl_pkg::LEVEL_9V);
    d.average = average;
    return d;
  endfunction

  // advance the bench state by one request and return the result it owes
  function automatic drive_t predict_drive(bit mode, logic [TEMP_W-1:0] temp,
                                           bit startup_done, bit warmup_done);
    int span;
    int sum;
    int valid;
    if (mode) begin
      // shutdown: no sampling, no tick counting, average untouched
      off_latched = 1'b1;
      level_q     = fanlvl_pkg::LEVEL_OFF;
    end else begin
      if (tick_cnt == tick_period) begin
        if (ring_pos >= WINDOW) begin
          ring_wrapped = 1'b1;
          ring_pos     = 0;
          ring_wraps++;
        end
        ring[ring_pos] = temp;
        // before the first wrap the newest sample stays out of the window
        span  = ring_wrapped ? WINDOW : ring_pos;
        sum   = 0;
        valid = 0;
        for (int n = 0; n < span; n++) begin
          if (ring[n] != 0) begin
            sum += ring[n];
            valid++;
          end
        end
        avg_q = (valid == 0) ? '0 : TEMP_W'(sum / valid);
        ring_pos++;
        tick_cnt = '0;
        samples_taken++;
      end
      if (!off_latched) begin
        if (!startup_done)
          level_q = fanlvl_pkg::LEVEL_12V;
        else if (!warmup_done)
          level_q = (avg_q <= thr_high) ? fanlvl_pkg::LEVEL_9V : fanlvl_pkg::LEVEL_12V;
        else if (avg_q <= thr_low)
          level_q = fanlvl_pkg::LEVEL_5V;
        else if (avg_q <= thr_high)
          level_q = fanlvl_pkg::LEVEL_9V;
        else
          level_q = fanlvl_pkg::LEVEL_12V;
      end
      tick_cnt = tick_cnt + 16'd1;
    end
    return fan_pins(level_q, avg_q);
  endfunction

  function automatic void add_tick(logic [TEMP_W-1:0] temp, logic startup_done,
                                   logic warmup_done, bit typed = 1'b0,
                                   logic [1:0] level = fanlvl_pkg::LEVEL_OFF,
                                   logic [TEMP_W-1:0] average = '0);
    plan_row_t r;
    r.kind         = ROW_TICK;
    r.temp         = temp;
    r.startup_done = startup_done;
    r.warmup_done  = warmup_done;
    r.typed        = typed;
    r.level        = level;
    r.average      = average;
    r.index        = '0;
    r.value        = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_write(logic [IDX_W-1:0] index,
                                    logic [DATA_W-1:0] value);
    plan_row_t r;
    r.kind         = ROW_WRITE;
    r.temp         = '0;
    r.startup_done = 1'b0;
    r.warmup_done  = 1'b0;
    r.typed        = 1'b0;
    r.level        = fanlvl_pkg::LEVEL_OFF;
    r.average      = '0;
    r.index        = index;
    r.value        = value;
    plan.push_back(r);
  endfunction

  // offer one request and return once the unit has taken it
  task automatic offer_request(bit mode, logic [TEMP_W-1:0] temp,
                               bit startup_done, bit warmup_done);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 24) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = mode;
    s_tdata  = {4'b0, warmup_done, startup_done, temp};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (mode)
      shutdowns_sent++;
  endtask

  // stop offering and wait until every owed result has come back
  task automatic settle_block(int extra);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_drive.size() != 0)
      @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // register write, only ever made with the unit idle
  task automatic write_register(logic [IDX_W-1:0] index, logic [DATA_W-1:0] value);
    settle_block(SETTLE);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      fanlvl_pkg::CFG_HIGH_THRESHOLD:   thr_high    = value[TEMP_W-1:0];
      fanlvl_pkg::CFG_LOW_THRESHOLD:    thr_low     = value[TEMP_W-1:0];
      fanlvl_pkg::CFG_TICKS_PER_SAMPLE: tick_period = value;
      default: ;
    endcase
    settings_written++;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result checker: every accepted result against the oldest owed one
  always @(posedge clk) begin
    drive_t got;
    drive_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.level   = m_tdata[1:0];
      got.enable  = m_tdata[2];
      got.sel_12v = m_tdata[3];
      got.sel_9v  = m_tdata[4];
      got.average = m_tdata[14:5];
      results_seen++;
      if (pending_drive.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
      end else begin
        want = pending_drive.pop_front();
        check_field("fan_level", want.level, got.level);
        check_field("fan_enable", want.enable, got.enable);
        check_field("select_12v", want.sel_12v, got.sel_12v);
        check_field("select_9v", want.sel_9v, got.sel_9v);
        check_field("average_temperature", want.average, got.average);
      end
    end
  end

  // receiver: random stalls, one long hold-off once traffic is under way
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst)
      @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (!long_hold_done && results_seen >= 400) begin
        // the sender keeps offering meanwhile, so the unit backs up and stalls its input
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        m_tready       = 1'b0;
      end else begin
        m_tready = steady || ($urandom_range(99) >= 24);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    drive_t            d;
    int                center;
    int                spread;
    int                items;
    int                t;
    int                want_period;
    int                hi;
    int                lo;
    bit                mode;
    bit                su;
    bit                wu;
    logic [TEMP_W-1:0] temp;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;

    tick_cnt     = '0;
    ring_pos     = 0;
    ring_wrapped = 1'b0;
    avg_q        = '0;
    off_latched  = 1'b0;
    level_q      = fanlvl_pkg::LEVEL_OFF;
    thr_high     = fanlvl_pkg::HIGH_THRESHOLD_RST;
    thr_low      = fanlvl_pkg::LOW_THRESHOLD_RST;
    tick_period  = fanlvl_pkg::TICKS_PER_SAMPLE_RST;
    steady       = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed plan
    // reset defaults, no sample yet, so the average is zero and the flags decide
    add_tick(10'd1023, 1'b0, 1'b0, 1'b1, fanlvl_pkg::LEVEL_12V, 10'd0);
    add_tick(10'd0,    1'b1, 1'b0, 1'b1, fanlvl_pkg::LEVEL_9V,  10'd0);
    add_tick(10'd1023, 1'b1, 1'b1, 1'b1, fanlvl_pkg::LEVEL_5V,  10'd0);
    add_tick(10'd512,  1'b0, 1'b1, 1'b1, fanlvl_pkg::LEVEL_12V, 10'd0);
    // period now equals the tick count, so the next tick samples
    add_write(fanlvl_pkg::CFG_TICKS_PER_SAMPLE, 16'd4);
    add_write(fanlvl_pkg::CFG_HIGH_THRESHOLD, 16'd1023);
    add_write(fanlvl_pkg::CFG_LOW_THRESHOLD, 16'd0);
    // first sample leaves the window empty; zero samples do not count
    add_tick(10'd1023, 1'b1, 1'b1);
    add_tick(10'd1,    1'b1, 1'b0);
    add_tick(10'd0,    1'b1, 1'b1);
    add_tick(10'd700,  1'b1, 1'b1);
    add_tick(10'd0,    1'b1, 1'b1);
    add_tick(10'd1023, 1'b1, 1'b0);
    add_tick(10'd1,    1'b0, 1'b1);
    add_tick(10'd300,  1'b1, 1'b1);
    add_tick(10'd1,    1'b1, 1'b1);
    add_tick(10'd1023, 1'b1, 1'b1);
    // crossed thresholds, low above high
    add_write(fanlvl_pkg::CFG_HIGH_THRESHOLD, 16'd0);
    add_write(fanlvl_pkg::CFG_LOW_THRESHOLD, 16'd1023);
    add_tick(10'd1023, 1'b1, 1'b1);
    add_tick(10'd1023, 1'b1, 1'b0);
    add_tick(10'd512,  1'b1, 1'b1);
    add_tick(10'd1,    1'b1, 1'b1);
    add_tick(10'd1023, 1'b1, 1'b0);
    add_tick(10'd0,    1'b1, 1'b1);
    add_tick(10'd1023, 1'b0, 1'b0);
    add_tick(10'd256,  1'b1, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_register(plan[i].index, plan[i].value);
      end else begin
        offer_request(1'b0, plan[i].temp, plan[i].startup_done, plan[i].warmup_done);
        d = predict_drive(1'b0, plan[i].temp, plan[i].startup_done, plan[i].warmup_done);
        if (plan[i].typed)
          d = fan_pins(plan[i].level, plan[i].average);
        pending_drive.push_back(d);
      end
    end

    // random phases: each with its own thresholds, period and temperature band
    for (int p = 0; p < PHASES; p++) begin
      center = $urandom_range(1023);
      spread = $urandom_range(5, 200);
      case (p)
        0: begin hi = 0;    lo = 0;    end
        1: begin hi = 1023; lo = 1023; end
        default: begin
          case ($urandom_range(5))
            0: begin hi = 1023; lo = 0; end
            1: begin hi = $urandom_range(1023); lo = $urandom_range(1023); end
            default: begin
              // thresholds near the band so averages cross them
              hi = center + $urandom_range(80) - 20;
              lo = center - $urandom_range(80);
            end
          endcase
        end
      endcase
      hi = (hi < 0) ? 0 : (hi > 1023) ? 1023 : hi;
      lo = (lo < 0) ? 0 : (lo > 1023) ? 1023 : lo;

      if (p == 5)
        want_period = 65535;            // no sample comes due in this phase
      else if (p % 4 == 0)
        want_period = 1;
      else if (p % 4 == 1)
        want_period = $urandom_range(2, 4);
      else if (p % 4 == 2)
        want_period = $urandom_range(1, 12);
      else
        want_period = $urandom_range(20, 60);
      // a period below the running count would stall sampling for a full 16-bit wrap
      if (want_period < tick_cnt)
        want_period = tick_cnt;

      write_register(fanlvl_pkg::CFG_HIGH_THRESHOLD, DATA_W'(hi));
      write_register(fanlvl_pkg::CFG_LOW_THRESHOLD, DATA_W'(lo));
      write_register(fanlvl_pkg::CFG_TICKS_PER_SAMPLE, DATA_W'(want_period));

      steady = (p == 3);
      items  = (p == 5) ? 40 : (p == PHASES - 1) ? 150 : 160;

      for (int k = 0; k < items; k++) begin
        t = $urandom_range(99);
        if (t < 8)
          temp = '0;
        else if (t < 12)
          temp = 10'd1023;
        else begin
          t = center + $urandom_range(2 * spread) - spread;
          temp = TEMP_W'((t < 0) ? 0 : (t > 1023) ? 1023 : t);
        end
        su = ($urandom_range(99) < 85);
        wu = ($urandom_range(99) < 60);
        // shutdown is permanent, so it only appears in the closing phase
        mode = (p == PHASES - 1) && (k == 0 || $urandom_range(99) < 10);
        offer_request(mode, temp, su, wu);
        pending_drive.push_back(predict_drive(mode, temp, su, wu));
      end
    end
    steady = 1'b0;

    settle_block(60);

    $display("tb: %0d requests (%0d shutdowns), %0d register writes, %0d results checked",
             requests_sent, shutdowns_sent, settings_written, results_seen);
    $display("tb: %0d samples stored, ring wrapped %0d times, %0d mismatches",
             samples_taken, ring_wraps, errors);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
